// ===== sv/rst_pkg.sv =====
// Package: shared types and codes for the ranked score table.
`timescale 1ns / 1ps
package rst_pkg;

  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned EXP_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RANK_W   = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned KEY_W    = LEVEL_W + EXP_W;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [ID_W-1:0]    entry_id;
    logic [LEVEL_W-1:0] level;
    logic [EXP_W-1:0]   experience;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // Key compare result of the shared comparator.
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

// ===== sv/rst_cmp.sv =====
// Shared key comparator: level first, then experience.
`timescale 1ns / 1ps
module rst_cmp (
  input  logic [rst_pkg::KEY_W-1:0] key_a,
  input  logic [rst_pkg::KEY_W-1:0] key_b,
  output rst_pkg::cmp_t             res
);
  import rst_pkg::*;

  // Level sits in the upper bits, so one unsigned compare covers both keys.
  assign res.gt = key_a > key_b;
  assign res.eq = key_a == key_b;

endmodule

// ===== sv/ranked_score_table.sv =====
// Top level: sorted score table with a sequencer over one row memory and one comparator.
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | rst_pkg::req_t
// out     | out | out_valid/out_stall | rst_pkg::rsp_t
// Errors, duplicates and type 3 requests are answered from the id table lookup alone.
// Insert adds a binary search and a shift down of every entry below the new slot;
// remove shifts every entry below it up; update reads the stored level, then moves
// the entry past each neighbor it overtakes. Each moved entry takes a read and a
// write on the single-port row memory.
// After reset a clearing pass zeroes the id table with in_stall high;
// in_stall stays high while a transaction is in work and until its result is taken.
`timescale 1ns / 1ps
module ranked_score_table #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ID_COUNT    = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rst_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rst_pkg::rsp_t  out_data
);
  import rst_pkg::*;

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned RW  = ID_W + KEY_W;
  localparam int unsigned EW  = AW + 1;
  localparam logic signed [CW:0] ONE_S = (CW+1)'(1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_DISPATCH, S_SRCH, S_SRCH_CMP, S_SHR_RD, S_SHR_WR,
    S_SHL_RD, S_SHL_WR, S_REM_DONE, S_UPD_RD, S_UPD_LV, S_UP_RD, S_UP_CMP,
    S_DN_RD, S_DN_CMP, S_PLACE
  } state_t;

  state_t state_r;

  // Row memory {id, level, experience}, one port.
  logic [RW-1:0] row_mem [TABLE_DEPTH];
  logic [RW-1:0] row_rd_r;
  logic          row_we;
  logic [AW-1:0] row_addr;
  logic [RW-1:0] row_wd;

  // Id table {ranked, rank}, one read and one write port.
  logic [EW-1:0] id_mem [ID_COUNT];
  logic [EW-1:0] id_rd_r;
  logic          id_we;
  logic [IW-1:0] id_waddr;
  logic [EW-1:0] id_wd;

  req_t               req_r;
  logic [CW-1:0]      count_r;
  logic signed [CW:0] lo_r, hi_r;
  logic [CW-1:0]      pos_r, i_r;
  logic [IW-1:0]      clr_r;
  logic [LEVEL_W-1:0] lv_r;
  logic               out_valid_r;
  rsp_t               out_r;
  logic               id_ok;
  logic [IW-1:0]      id_idx;
  logic signed [CW:0] mid_sum;
  logic signed [CW:0] mid;
  cmp_t               cres;
  logic [KEY_W-1:0]   key_in;

  function automatic rsp_t pack_rsp(logic [STATUS_W-1:0] st, logic [RANK_W-1:0] rk,
                                    logic [COUNT_W-1:0] cn);
    rsp_t r;
    r.status      = st;
    r.rank        = rk;
    r.entry_count = cn;
    return r;
  endfunction

  assign id_ok   = 32'(req_r.entry_id) < ID_COUNT;
  assign id_idx  = IW'(req_r.entry_id);
  assign mid_sum = lo_r + hi_r;
  assign mid     = mid_sum >>> 1;
  assign key_in  = {lv_r, req_r.experience};

  rst_cmp u_cmp (.key_a(key_in), .key_b(row_rd_r[KEY_W-1:0]), .res(cres));

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_addr] <= row_wd;
    row_rd_r <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_wd;
    id_rd_r <= id_mem[id_idx];
  end

  // Memory controls by state; i_r is the slot being filled.
  always_comb begin
    row_we   = 1'b0;
    row_addr = AW'(i_r);
    row_wd   = row_rd_r;
    id_we    = 1'b0;
    id_waddr = IW'(row_rd_r[RW-1 -: ID_W]);
    id_wd    = {1'b1, AW'(i_r)};
    case (state_r)
      S_CLEAR: begin
        id_we    = 1'b1;
        id_waddr = clr_r;
        id_wd    = '0;
      end
      S_SRCH:             row_addr = mid[AW-1:0];
      S_SHR_RD, S_UP_RD:  row_addr = AW'(i_r - 1'b1);
      S_SHL_RD, S_DN_RD:  row_addr = AW'(i_r + 1'b1);
      S_SHR_WR, S_SHL_WR: begin
        row_we = 1'b1;
        id_we  = 1'b1;
      end
      // Move the neighbor into the slot when the entry passes it.
      S_UP_CMP: begin
        row_we = cres.gt;
        id_we  = cres.gt;
      end
      S_DN_CMP: begin
        row_we = !cres.gt && !cres.eq;
        id_we  = !cres.gt && !cres.eq;
      end
      S_PLACE: begin
        row_we   = 1'b1;
        row_wd   = {req_r.entry_id, lv_r, req_r.experience};
        id_we    = 1'b1;
        id_waddr = id_idx;
      end
      S_REM_DONE: begin
        id_we    = 1'b1;
        id_waddr = id_idx;
        id_wd    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (clr_r == IW'(ID_COUNT - 1)) state_r <= S_IDLE;
          else clr_r <= clr_r + 1'b1;
        end
        S_IDLE: begin
          if (out_valid_r) begin
            if (!out_stall) out_valid_r <= 1'b0;
          end else if (in_valid) begin
            req_r   <= in_data;
            lv_r    <= in_data.level;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: state_r <= S_DISPATCH;  // id table read settles
        S_DISPATCH: begin
          pos_r <= CW'(id_rd_r[AW-1:0]);
          i_r   <= CW'(id_rd_r[AW-1:0]);
          if (req_r.req_type == REQ_NOP) begin
            out_r <= pack_rsp(ST_OK, '0, COUNT_W'(count_r));
            out_valid_r <= 1'b1; state_r <= S_IDLE;
          end else if (!id_ok) begin
            out_r <= pack_rsp(ST_UNKNOWN, '0, COUNT_W'(count_r));
            out_valid_r <= 1'b1; state_r <= S_IDLE;
          end else if (req_r.req_type == REQ_INSERT) begin
            if (id_rd_r[AW]) begin
              out_r <= pack_rsp(ST_DUP, RANK_W'(id_rd_r[AW-1:0]), COUNT_W'(count_r));
              out_valid_r <= 1'b1; state_r <= S_IDLE;
            end else if (count_r >= CW'(TABLE_DEPTH)) begin
              out_r <= pack_rsp(ST_FULL, '0, COUNT_W'(count_r));
              out_valid_r <= 1'b1; state_r <= S_IDLE;
            end else begin
              lo_r    <= '0;
              hi_r    <= $signed({1'b0, count_r}) - ONE_S;
              state_r <= S_SRCH;
            end
          end else if (!id_rd_r[AW]) begin
            out_r <= pack_rsp(ST_UNKNOWN, '0, COUNT_W'(count_r));
            out_valid_r <= 1'b1; state_r <= S_IDLE;
          end else if (req_r.req_type == REQ_UPDATE) begin
            state_r <= S_UPD_RD;
          end else begin
            state_r <= S_SHL_RD;
          end
        end
        S_SRCH: begin
          if (hi_r < lo_r) begin
            pos_r <= CW'(lo_r); i_r <= count_r; state_r <= S_SHR_RD;
          end else begin
            state_r <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          // Stop on the first equal key probed; the new entry goes in front of it.
          if (cres.eq) begin
            pos_r <= CW'(mid); i_r <= count_r; state_r <= S_SHR_RD;
          end else if (cres.gt) begin
            hi_r <= mid - ONE_S; state_r <= S_SRCH;
          end else begin
            lo_r <= mid + ONE_S; state_r <= S_SRCH;
          end
        end
        S_SHR_RD: state_r <= (i_r > pos_r) ? S_SHR_WR : S_PLACE;
        S_SHR_WR: begin i_r <= i_r - 1'b1; state_r <= S_SHR_RD; end
        S_SHL_RD: state_r <= (i_r + 1'b1 < count_r) ? S_SHL_WR : S_REM_DONE;
        S_SHL_WR: begin i_r <= i_r + 1'b1; state_r <= S_SHL_RD; end
        S_REM_DONE: begin
          count_r <= count_r - 1'b1;
          out_r <= pack_rsp(ST_OK, RANK_W'(pos_r), COUNT_W'(count_r - 1'b1));
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        S_UPD_RD: state_r <= S_UPD_LV;
        // Keep the stored level; only the experience changes.
        S_UPD_LV: begin
          lv_r    <= row_rd_r[KEY_W-1 -: LEVEL_W];
          state_r <= S_UP_RD;
        end
        S_UP_RD: state_r <= (i_r == '0) ? S_DN_RD : S_UP_CMP;
        S_UP_CMP: begin
          if (cres.gt) begin i_r <= i_r - 1'b1; state_r <= S_UP_RD; end
          else state_r <= S_DN_RD;
        end
        S_DN_RD: state_r <= (i_r + 1'b1 < count_r) ? S_DN_CMP : S_PLACE;
        S_DN_CMP: begin
          if (!cres.gt && !cres.eq) begin i_r <= i_r + 1'b1; state_r <= S_DN_RD; end
          else state_r <= S_PLACE;
        end
        S_PLACE: begin
          if (req_r.req_type == REQ_INSERT) begin
            count_r <= count_r + 1'b1;
            out_r <= pack_rsp(ST_OK, RANK_W'(i_r), COUNT_W'(count_r + 1'b1));
          end else begin
            out_r <= pack_rsp(ST_OK, RANK_W'(i_r), COUNT_W'(count_r));
          end
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("ready while busy");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE) else $error("result while busy");

endmodule

// ===== test/tb_ranked_score_table.sv =====
// Testbench for the ranked score table: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module tb_ranked_score_table;
  import rst_pkg::*;

  localparam int DEPTH    = 256;
  localparam int IDS      = 1024;
  localparam int WD_LIMIT = 20000;
  localparam int HOLD_LEN = 400;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  req_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  rsp_t  out_data;

  always #10 clk = ~clk;

  ranked_score_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state
  logic [ID_W-1:0]    tbl_id [DEPTH];
  logic [LEVEL_W-1:0] tbl_lev [DEPTH];
  logic [EXP_W-1:0]   tbl_exp [DEPTH];
  bit                 id_on [IDS];
  int                 id_rank [IDS];
  int                 n_rows = 0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_recv = 1'b0;
  int   hold_cycles = 0;
  int   hold_req_n = 0;
  int   hold_seen_n = 0;
  int   idle_cycles = 0;
  bit   accepted_in = 1'b0;

  // +1 above, -1 below, 0 equal
  function automatic int key_order(logic [LEVEL_W-1:0] la, logic [EXP_W-1:0] ea,
                                   logic [LEVEL_W-1:0] lb, logic [EXP_W-1:0] eb);
    if (la != lb) return (la > lb) ? 1 : -1;
    if (ea != eb) return (ea > eb) ? 1 : -1;
    return 0;
  endfunction

  task automatic swap_rows(int a, int b);
    logic [ID_W-1:0] ti;
    logic [LEVEL_W-1:0] tl;
    logic [EXP_W-1:0] te;
    ti = tbl_id[a];  tbl_id[a] = tbl_id[b];  tbl_id[b] = ti;
    tl = tbl_lev[a]; tbl_lev[a] = tbl_lev[b]; tbl_lev[b] = tl;
    te = tbl_exp[a]; tbl_exp[a] = tbl_exp[b]; tbl_exp[b] = te;
    id_rank[tbl_id[a]] = a;
    id_rank[tbl_id[b]] = b;
  endtask

  function automatic rsp_t mk_rsp(logic [STATUS_W-1:0] st, int rk);
    rsp_t r;
    r.status = st;
    r.rank = rk[RANK_W-1:0];
    r.entry_count = n_rows[COUNT_W-1:0];
    return r;
  endfunction

  task automatic apply_request(req_t q);
    int id, pos, lo, hi, mid, c;
    bit known;
    id = q.entry_id;
    known = 1'b0;
    pos = 0;
    if (q.req_type == REQ_NOP) begin
      expected_rsps.push_back(mk_rsp(ST_OK, 0));
      return;
    end
    if (id < IDS && id_on[id] && id_rank[id] < n_rows) begin
      known = 1'b1;
      pos = id_rank[id];
    end
    if (q.req_type == REQ_INSERT) begin
      if (known) begin
        expected_rsps.push_back(mk_rsp(ST_DUP, pos));
        return;
      end
      if (n_rows >= DEPTH) begin
        expected_rsps.push_back(mk_rsp(ST_FULL, 0));
        return;
      end
      lo = 0;
      hi = n_rows - 1;
      forever begin
        if (hi < lo) begin
          pos = lo;
          break;
        end
        mid = (lo + hi) / 2;
        c = key_order(q.level, q.experience, tbl_lev[mid], tbl_exp[mid]);
        if (c == 0) begin
          pos = mid;
          break;
        end
        if (c < 0) lo = mid + 1;
        else hi = mid - 1;
      end
      for (int i = n_rows; i > pos; i--) begin
        tbl_id[i] = tbl_id[i-1];
        tbl_lev[i] = tbl_lev[i-1];
        tbl_exp[i] = tbl_exp[i-1];
        id_rank[tbl_id[i]] = i;
      end
      tbl_id[pos] = q.entry_id;
      tbl_lev[pos] = q.level;
      tbl_exp[pos] = q.experience;
      id_rank[id] = pos;
      id_on[id] = 1'b1;
      n_rows++;
      expected_rsps.push_back(mk_rsp(ST_OK, pos));
      return;
    end
    if (!known) begin
      expected_rsps.push_back(mk_rsp(ST_UNKNOWN, 0));
      return;
    end
    if (q.req_type == REQ_UPDATE) begin
      tbl_exp[pos] = q.experience;
      while (pos > 0 && key_order(tbl_lev[pos], q.experience,
                                  tbl_lev[pos-1], tbl_exp[pos-1]) > 0) begin
        swap_rows(pos, pos - 1);
        pos--;
      end
      while (pos + 1 < n_rows && key_order(tbl_lev[pos], q.experience,
                                           tbl_lev[pos+1], tbl_exp[pos+1]) < 0) begin
        swap_rows(pos, pos + 1);
        pos++;
      end
      id_rank[id] = pos;
      expected_rsps.push_back(mk_rsp(ST_OK, pos));
      return;
    end
    for (int i = pos; i + 1 < n_rows; i++) begin
      tbl_id[i] = tbl_id[i+1];
      tbl_lev[i] = tbl_lev[i+1];
      tbl_exp[i] = tbl_exp[i+1];
      id_rank[tbl_id[i]] = i;
    end
    n_rows--;
    id_on[id] = 1'b0;
    expected_rsps.push_back(mk_rsp(ST_OK, pos));
  endtask

  // Driver: hold the transaction until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_in) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_recv ? 1'b1 : ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    accepted_in <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) apply_request(in_data);
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            errors++;
          end
          if (out_data.rank !== e.rank) begin
            $error("rank expected %0d actual %0d", e.rank, out_data.rank);
            errors++;
          end
          if (out_data.entry_count !== e.entry_count) begin
            $error("entry_count expected %0d actual %0d", e.entry_count,
                   out_data.entry_count);
            errors++;
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req_n != hold_seen_n) begin
      hold_seen_n <= hold_req_n;
      hold_cycles <= HOLD_LEN;
      hold_recv <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      hold_recv <= 1'b1;
    end else begin
      hold_recv <= 1'b0;
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Shadow of the ids that are live once all queued requests apply, for well-formed random traffic
  bit live_ids [IDS];
  int live_n = 0;

  function automatic req_t build_req(logic [1:0] t, int id, int lev, int unsigned ex);
    req_t r;
    r.req_type = t;
    r.entry_id = id[ID_W-1:0];
    r.level = lev[LEVEL_W-1:0];
    r.experience = EXP_W'(ex);
    return r;
  endfunction

  function automatic int unsigned rand_exp();
    case ($urandom_range(3))
      0: return 0;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      default: return $urandom() & 32'h7fff_ffff;
    endcase
  endfunction

  function automatic int pick_live();
    int id;
    repeat (50) begin
      id = $urandom_range(1, IDS - 1);
      if (live_ids[id]) return id;
    end
    return $urandom_range(1, IDS - 1);
  endfunction

  task automatic queue_req(req_t r);
    int id;
    id = r.entry_id;
    if (r.req_type == REQ_INSERT && !live_ids[id] && live_n < DEPTH) begin
      live_ids[id] = 1'b1;
      live_n++;
    end else if (r.req_type == REQ_REMOVE && live_ids[id]) begin
      live_ids[id] = 1'b0;
      live_n--;
    end
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int n, int sp, int rp);
    int id, t;
    send_idle_pct = sp;
    recv_stall_pct = rp;
    repeat (n) begin
      t = $urandom_range(99);
      if (t < 45 && live_n < 200) begin
        id = $urandom_range(1, IDS - 1);
        queue_req(build_req(REQ_INSERT, id, $urandom_range(3) == 0 ? $urandom_range(255)
                            : $urandom_range(4), rand_exp()));
      end else if (t < 70) begin
        queue_req(build_req(REQ_UPDATE, pick_live(), $urandom_range(255), rand_exp()));
      end else if (t < 90) begin
        queue_req(build_req(REQ_REMOVE, pick_live(), $urandom_range(255), rand_exp()));
      end else begin
        // noise: any type, any id
        queue_req(build_req(2'($urandom_range(3)), $urandom_range(0, IDS - 1),
                            $urandom_range(255), rand_exp()));
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every request type, error statuses
    queue_req(build_req(REQ_REMOVE, 5, 0, 0));
    queue_req(build_req(REQ_UPDATE, 5, 0, 0));
    queue_req(build_req(REQ_INSERT, 1023, 255, 32'h7fff_ffff));
    queue_req(build_req(REQ_INSERT, 1, 0, 0));
    queue_req(build_req(REQ_INSERT, 2, 10, 100));
    queue_req(build_req(REQ_INSERT, 3, 10, 100));
    queue_req(build_req(REQ_INSERT, 4, 10, 100));
    queue_req(build_req(REQ_INSERT, 3, 1, 1));
    queue_req(build_req(REQ_UPDATE, 1, 200, 32'h7fff_ffff));
    queue_req(build_req(REQ_UPDATE, 1023, 7, 0));
    queue_req(build_req(REQ_UPDATE, 2, 0, 99));
    queue_req(build_req(REQ_NOP, 0, 255, 32'h7fff_ffff));
    queue_req(build_req(REQ_INSERT, 0, 0, 0));
    queue_req(build_req(REQ_REMOVE, 3, 0, 0));
    queue_req(build_req(REQ_REMOVE, 1023, 0, 0));
    queue_req(build_req(REQ_INSERT, 512, 128, 32'h4000_0000));
    queue_req(build_req(REQ_REMOVE, 1, 0, 0));
    wait_drain();

    random_phase(270, 0, 0);
    random_phase(270, 53, 0);
    random_phase(270, 0, 53);
    random_phase(270, 32, 32);

    // Fill the table to full, then overflow, under a long receiver hold-off
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req_n++;
    for (int id = 1; id < IDS && live_n < DEPTH; id++)
      if (!live_ids[id])
        queue_req(build_req(REQ_INSERT, id, $urandom_range(255), rand_exp()));
    for (int k = 0; k < 4; k++)
      queue_req(build_req(REQ_INSERT, 1000 + k, $urandom_range(255), rand_exp()));
    wait_drain();

    // Random traffic with sender pauses, then removal of about half of the live ids
    random_phase(200, 32, 32);
    for (int id = 1; id < IDS; id++)
      if (live_ids[id] && $urandom_range(1))
        queue_req(build_req(REQ_REMOVE, id, 0, 0));
    wait_drain();
    random_phase(200, 0, 0);

    repeat (600) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rst_pkg.sv
sv/rst_cmp.sv
sv/ranked_score_table.sv
test/tb_ranked_score_table.sv
